// ===== hw/rtl/mm4x4_pkg.sv =====
package mm4x4_pkg;

  localparam int DIM_DEFAULT = 4;
  localparam int DATA_W      = 32;
  // Index width inside the cell chain, wide enough for a DIM of up to 8
  localparam int IDX_W       = 3;

  localparam logic [1:0] CMD_LOAD_LEFT  = 2'd0;
  localparam logic [1:0] CMD_LOAD_RIGHT = 2'd1;
  localparam logic [1:0] CMD_COMPUTE    = 2'd2;

  // One product element moving down the chain of cells
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] acc;
  } token_t;

  // Element write broadcast to all cells
  typedef struct packed {
    logic              left_en;
    logic              right_en;
    logic [IDX_W-1:0]  cell_sel;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] data;
  } wr_t;

endpackage

// ===== hw/rtl/mm4x4_in_if.sv =====
interface mm4x4_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    command;
  logic [1:0]                    row_index;
  logic [1:0]                    col_index;
  logic signed [mm4x4_pkg::DATA_W-1:0] element;

  modport source (output valid, command, row_index, col_index, element, input ready);
  modport sink   (input valid, command, row_index, col_index, element, output ready);
endinterface

// ===== hw/rtl/mm4x4_out_if.sv =====
interface mm4x4_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    out_row;
  logic [1:0]                    out_col;
  logic signed [mm4x4_pkg::DATA_W-1:0] product_value;
  logic                          last_element;

  modport source (output valid, out_row, out_col, product_value, last_element, input ready);
  modport sink   (input valid, out_row, out_col, product_value, last_element, output ready);
endinterface

// ===== hw/rtl/matrix_multiply_4x4_core.sv =====
// Integer DIM x DIM matrix multiplier (DIM = 4 by default, 2 to 4). Load items
// (command 0 = left, 1 = right) write one 32-bit element at row_index/col_index
// and are taken one per cycle while the core is idle; loads outside the matrix
// and command 3 are dropped. A compute item (command 2) streams out all DIM*DIM
// elements of left x right in row-major order, last_element set on the final
// one, with products and sums wrapping modulo 2^32. The product is formed in a
// chain of DIM multiply-accumulate cells, cell k holding left column k and right
// row k; one element enters the chain per cycle while the output is not stalled
// and passes the two registers of each cell and then the output register. A
// compute item holds the input until its last result is taken. Both matrices
// are zero after reset; no clearing pass is needed.
module matrix_multiply_4x4_core #(
  parameter int DIM = mm4x4_pkg::DIM_DEFAULT
) (
  input logic clk,
  input logic rst_n,
  mm4x4_in_if.sink    in_ch,
  mm4x4_out_if.source out_ch
);

  localparam int IW = $clog2(DIM);

  logic                         busy_r;
  logic                         issue_r;
  logic [IW-1:0]                row_r, col_r;
  logic                         en;
  logic                         in_acc;
  logic                         load_ok;
  logic                         start;
  logic                         issue_last;
  mm4x4_pkg::wr_t               wr;
  mm4x4_pkg::token_t            chain [DIM+1];

  logic                         out_valid_r;
  logic [1:0]                   out_row_r, out_col_r;
  logic [mm4x4_pkg::DATA_W-1:0] out_value_r;
  logic                         out_last_r;

  // whole chain moves when the output register is free or being emptied
  assign en     = !out_valid_r || out_ch.ready;

  // one item in flight: loads wait until the last product has left
  assign in_ch.ready = !busy_r;
  assign in_acc      = in_ch.valid && !busy_r;

  assign load_ok = ((mm4x4_pkg::IDX_W + 1)'(in_ch.row_index) <
                    (mm4x4_pkg::IDX_W + 1)'(DIM)) &&
                   ((mm4x4_pkg::IDX_W + 1)'(in_ch.col_index) <
                    (mm4x4_pkg::IDX_W + 1)'(DIM));
  assign start   = in_acc && (in_ch.command == mm4x4_pkg::CMD_COMPUTE);

  // left element goes to cell col at row, right element to cell row at col
  always_comb begin
    wr.left_en  = in_acc && load_ok && (in_ch.command == mm4x4_pkg::CMD_LOAD_LEFT);
    wr.right_en = in_acc && load_ok && (in_ch.command == mm4x4_pkg::CMD_LOAD_RIGHT);
    wr.data     = in_ch.element;
    if (in_ch.command == mm4x4_pkg::CMD_LOAD_LEFT) begin
      wr.cell_sel = mm4x4_pkg::IDX_W'(in_ch.col_index);
      wr.addr     = mm4x4_pkg::IDX_W'(in_ch.row_index);
    end else begin
      wr.cell_sel = mm4x4_pkg::IDX_W'(in_ch.row_index);
      wr.addr     = mm4x4_pkg::IDX_W'(in_ch.col_index);
    end
  end

  assign issue_last = (row_r == IW'(DIM - 1)) && (col_r == IW'(DIM - 1));

  // issue sequencer: walks row/col over the product, one element per cycle while the chain moves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      issue_r <= 1'b0;
      row_r   <= '0;
      col_r   <= '0;
    end else begin
      if (start) begin
        busy_r  <= 1'b1;
        issue_r <= 1'b1;
        row_r   <= '0;
        col_r   <= '0;
      end else begin
        if (en && issue_r) begin
          if (issue_last) begin
            issue_r <= 1'b0;
          end else if (col_r == IW'(DIM - 1)) begin
            col_r <= '0;
            row_r <= row_r + 1'b1;
          end else begin
            col_r <= col_r + 1'b1;
          end
        end
        if (out_valid_r && out_ch.ready && out_last_r) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    chain[0].valid = issue_r;
    chain[0].last  = issue_last;
    chain[0].row   = mm4x4_pkg::IDX_W'(row_r);
    chain[0].col   = mm4x4_pkg::IDX_W'(col_r);
    chain[0].acc   = '0;
  end

  for (genvar k = 0; k < DIM; k++) begin : g_cell
    mm4x4_cell #(
      .DIM     (DIM),
      .CELL_ID (k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .wr      (wr),
      .tok_in  (chain[k]),
      .tok_out (chain[k+1])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= chain[DIM].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_row_r   <= chain[DIM].row[1:0];
      out_col_r   <= chain[DIM].col[1:0];
      out_value_r <= chain[DIM].acc;
      out_last_r  <= chain[DIM].last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_row       = out_row_r;
  assign out_ch.out_col       = out_col_r;
  assign out_ch.product_value = out_value_r;
  assign out_ch.last_element  = out_last_r;

endmodule

// ===== hw/rtl/mm4x4_cell.sv =====
module mm4x4_cell #(
  parameter int DIM     = mm4x4_pkg::DIM_DEFAULT,
  parameter int CELL_ID = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  mm4x4_pkg::wr_t    wr,
  input  mm4x4_pkg::token_t tok_in,
  output mm4x4_pkg::token_t tok_out
);

  localparam int IW = $clog2(DIM);

  // left column CELL_ID (indexed by row), right row CELL_ID (indexed by col)
  logic [mm4x4_pkg::DATA_W-1:0] left_mem_r  [DIM];
  logic [mm4x4_pkg::DATA_W-1:0] right_mem_r [DIM];

  mm4x4_pkg::token_t            tok_a_r, tok_b_r, tok_b_nxt;
  logic [mm4x4_pkg::DATA_W-1:0] prod_r, prod_nxt;
  logic                         sel_hit;

  assign sel_hit  = (wr.cell_sel == mm4x4_pkg::IDX_W'(CELL_ID));
  // low 32 bits of the product, wraps like the sum
  assign prod_nxt = mm4x4_pkg::DATA_W'(left_mem_r[tok_in.row[IW-1:0]] *
                                       right_mem_r[tok_in.col[IW-1:0]]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIM; i++) begin
        left_mem_r[i]  <= '0;
        right_mem_r[i] <= '0;
      end
    end else begin
      if (wr.left_en && sel_hit) begin
        left_mem_r[wr.addr[IW-1:0]] <= wr.data;
      end
      if (wr.right_en && sel_hit) begin
        right_mem_r[wr.addr[IW-1:0]] <= wr.data;
      end
    end
  end

  always_comb begin
    tok_b_nxt     = tok_a_r;
    tok_b_nxt.acc = tok_a_r.acc + prod_r;
  end

  // stage A: multiply, stage B: accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_a_r <= '0;
      tok_b_r <= '0;
      prod_r  <= '0;
    end else if (en) begin
      tok_a_r <= tok_in;
      prod_r  <= prod_nxt;
      tok_b_r <= tok_b_nxt;
    end
  end

  assign tok_out = tok_b_r;

endmodule
